// ===== rtl/irx_pkg.sv =====
// ----------------------------------------------------------------------------
// irx_pkg
// Shared constants and helpers for the interval run extractor: set operation
// codes, locus pair codes, locus width and saturating locus arithmetic.
// ----------------------------------------------------------------------------
package irx_pkg;

  localparam int LOCI_PER_WORD_DEF = 16;
  localparam int LOCUS_W           = 31;
  localparam int OFF_W             = 6;   // holds an in-word offset up to 32
  localparam int MODE_W            = 3;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [LOCUS_W-1:0] LOCUS_MAX = {LOCUS_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REF_ONLY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REL_ONLY  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNION     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEITHER   = 3'd4;

  localparam logic [1:0] PAIR_BOTH = 2'b11;
  localparam logic [1:0] PAIR_REF  = 2'b01;
  localparam logic [1:0] PAIR_REL  = 2'b10;
  localparam logic [1:0] PAIR_NONE = 2'b00;

  function automatic logic qualifies(logic [MODE_W-1:0] mode, logic [1:0] pair);
    logic q;
    q = 1'b0;
    unique case (mode)
      MODE_INTERSECT: q = (pair == PAIR_BOTH);
      MODE_REF_ONLY:  q = (pair == PAIR_REF);
      MODE_REL_ONLY:  q = (pair == PAIR_REL);
      MODE_UNION:     q = (pair != PAIR_NONE);
      MODE_NEITHER:   q = (pair == PAIR_NONE);
      default:        q = 1'b0;
    endcase
    return q;
  endfunction

  function automatic logic [LOCUS_W-1:0] sat_add(logic [LOCUS_W-1:0] base,
                                                 logic [OFF_W-1:0] off);
    logic [LOCUS_W:0] sum;
    sum = {1'b0, base} + {{(LOCUS_W + 1 - OFF_W){1'b0}}, off};
    return sum[LOCUS_W] ? LOCUS_MAX : sum[LOCUS_W-1:0];
  endfunction

  // locus just before a word's first locus
  function automatic logic [LOCUS_W-1:0] prev_locus(logic [LOCUS_W-1:0] base);
    logic [LOCUS_W-1:0] p;
    if (base == LOCUS_MAX) begin
      p = LOCUS_MAX;
    end else if (base == '0) begin
      p = '0;
    end else begin
      p = base - LOCUS_W'(1);
    end
    return p;
  endfunction

endpackage

// ===== rtl/irx_if.sv =====
// ----------------------------------------------------------------------------
// irx_if
// Channel interfaces of the interval run extractor: input words, result
// intervals and the set operation register write channel.
// ----------------------------------------------------------------------------
interface irx_in_if #(parameter int LOCI = irx_pkg::LOCI_PER_WORD_DEF) ();
  localparam int CNT_W = $clog2(LOCI + 1);

  logic                 valid;
  logic                 ready;
  logic [2*LOCI-1:0]    locus_pairs;
  logic [CNT_W-1:0]     valid_count;
  logic                 map_end;

  modport source (output valid, locus_pairs, valid_count, map_end, input ready);
  modport sink   (input valid, locus_pairs, valid_count, map_end, output ready);
endinterface

interface irx_out_if ();
  logic                         valid;
  logic                         ready;
  logic [irx_pkg::LOCUS_W-1:0]  run_start;
  logic [irx_pkg::LOCUS_W-1:0]  run_end;
  logic                         last_result;

  modport source (output valid, run_start, run_end, last_result, input ready);
  modport sink   (input valid, run_start, run_end, last_result, output ready);
endinterface

interface irx_cfg_if ();
  logic                        valid;
  logic                        ready;
  logic [irx_pkg::MODE_W-1:0]  set_mode;

  modport source (output valid, set_mode, input ready);
  modport sink   (input valid, set_mode, output ready);
endinterface

// ===== rtl/irx_front.sv =====
// ----------------------------------------------------------------------------
// irx_front
// Accepts input words, tests every valid locus against the set operation and
// tracks the locus number of each word's first locus.
// ----------------------------------------------------------------------------
module irx_front #(
  parameter int LOCI = irx_pkg::LOCI_PER_WORD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2*LOCI-1:0]            in_locus_pairs,
  input  logic [$clog2(LOCI+1)-1:0]    in_valid_count,
  input  logic                         in_map_end,
  input  logic                         cfg_valid,
  input  logic [irx_pkg::MODE_W-1:0]   cfg_set_mode,
  input  logic                         q_full,
  output logic                         q_wr,
  output logic [LOCI-1:0]              q_qual,
  output logic [$clog2(LOCI+1)-1:0]    q_count,
  output logic                         q_map_end,
  output logic [irx_pkg::LOCUS_W-1:0]  q_base
);
  import irx_pkg::*;

  localparam int CNT_W = $clog2(LOCI + 1);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [LOCUS_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]   count;

  assign in_ready = !q_full;
  assign q_wr     = in_valid && in_ready;

  always_comb begin
    count = (in_valid_count > CNT_W'(LOCI)) ? CNT_W'(LOCI) : in_valid_count;
    for (int k = 0; k < LOCI; k++) begin
      q_qual[k] = qualifies(mode_r, in_locus_pairs[2*k +: 2]) && (CNT_W'(k) < count);
    end
  end

  assign q_count   = count;
  assign q_map_end = in_map_end;
  assign q_base    = base_r;

  always_comb begin
    mode_nxt = cfg_valid ? cfg_set_mode : mode_r;
    base_nxt = base_r;
    if (q_wr) begin
      // restart numbering after the last word of a map
      base_nxt = in_map_end ? '0 : sat_add(base_r, OFF_W'(count));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INTERSECT;
      base_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

// ===== rtl/irx_queue.sv =====
// ----------------------------------------------------------------------------
// irx_queue
// Short first-in first-out queue of classified words between the front end
// and the interval back end.
// ----------------------------------------------------------------------------
module irx_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = irx_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr && !rd) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (rd && !wr) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/irx_back.sv =====
// ----------------------------------------------------------------------------
// irx_back
// Turns classified words into intervals: marks run starts and ends on load,
// then emits one interval per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module irx_back #(
  parameter int LOCI = irx_pkg::LOCI_PER_WORD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         hd_empty,
  output logic                         hd_rd,
  input  logic [LOCI-1:0]              hd_qual,
  input  logic [$clog2(LOCI+1)-1:0]    hd_count,
  input  logic                         hd_map_end,
  input  logic [irx_pkg::LOCUS_W-1:0]  hd_base,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [irx_pkg::LOCUS_W-1:0]  out_run_start,
  output logic [irx_pkg::LOCUS_W-1:0]  out_run_end,
  output logic                         out_last_result
);
  import irx_pkg::*;

  localparam int CNT_W = $clog2(LOCI + 1);

  function automatic logic [CNT_W-1:0] lowest(logic [LOCI-1:0] v);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int k = LOCI - 1; k >= 0; k--) begin
      if (v[k]) r = CNT_W'(k);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] highest(logic [LOCI-1:0] v);
    logic [CNT_W-1:0] r;
    r = '0;
    for (int k = 0; k < LOCI; k++) begin
      if (v[k]) r = CNT_W'(k);
    end
    return r;
  endfunction

  // run state carried across words
  logic               in_run_r, in_run_nxt;
  logic [LOCUS_W-1:0] open_start_r, open_start_nxt;
  // word being worked off
  logic [LOCI-1:0]    smask_r, smask_nxt;
  logic [LOCI-1:0]    emask_r, emask_nxt;
  logic               close_r, close_nxt;
  logic [LOCUS_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]   vc_r, vc_nxt;
  logic [LOCUS_W-1:0] carry_r, carry_nxt;
  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [LOCUS_W-1:0] ostart_r, ostart_nxt;
  logic [LOCUS_W-1:0] oend_r, oend_nxt;
  logic               olast_r, olast_nxt;

  logic               ends_any, starts_any, active, emit_fire, emit_last, start_own;
  logic               load, fin_run;
  logic [CNT_W-1:0]   e_idx, s_idx, end_idx, hs_idx;
  logic [LOCI-1:0]    below_e, at_e, vmask, prev_q, ld_ends, ld_starts;
  logic [LOCUS_W-1:0] emit_start, emit_end;

  always_comb begin
    ends_any   = |emask_r;
    starts_any = |smask_r;
    e_idx      = lowest(emask_r);
    s_idx      = lowest(smask_r);
    for (int k = 0; k < LOCI; k++) begin
      below_e[k] = (CNT_W'(k) < e_idx);
      at_e[k]    = (CNT_W'(k) == e_idx);
    end

    // a run closes at the locus before the end mark, or at the word's last locus
    end_idx    = ends_any ? e_idx : vc_r;
    start_own  = starts_any && (!ends_any || (s_idx < e_idx));
    emit_start = start_own ? sat_add(base_r, OFF_W'(s_idx)) : carry_r;
    emit_end   = (end_idx == '0) ? prev_locus(base_r)
                                 : sat_add(base_r, OFF_W'(end_idx) - OFF_W'(1));
    emit_last  = ends_any ? (((emask_r & ~at_e) == '0) && !close_r) : 1'b1;

    active    = ends_any || close_r;
    emit_fire = active && (!ovalid_r || out_ready);
    load      = !hd_empty && (!active || (emit_fire && emit_last));

    // mark starts and ends of the head word against the carried run state
    for (int k = 0; k < LOCI; k++) begin
      vmask[k] = (CNT_W'(k) < hd_count);
    end
    prev_q    = (hd_qual << 1) | LOCI'(in_run_r);
    ld_ends   = ~hd_qual & prev_q & vmask;
    ld_starts = hd_qual & ~prev_q;
    fin_run   = in_run_r;
    for (int k = 0; k < LOCI; k++) begin
      if (CNT_W'(k + 1) == hd_count) fin_run = hd_qual[k];
    end
    hs_idx = highest(ld_starts);
  end

  assign hd_rd = load;

  always_comb begin
    in_run_nxt     = in_run_r;
    open_start_nxt = open_start_r;
    smask_nxt      = smask_r;
    emask_nxt      = emask_r;
    close_nxt      = close_r;
    base_nxt       = base_r;
    vc_nxt         = vc_r;
    carry_nxt      = carry_r;
    ovalid_nxt     = ovalid_r;
    ostart_nxt     = ostart_r;
    oend_nxt       = oend_r;
    olast_nxt      = olast_r;

    if (emit_fire) begin
      ovalid_nxt = 1'b1;
      ostart_nxt = emit_start;
      oend_nxt   = emit_end;
      olast_nxt  = emit_last;
      if (ends_any) begin
        // drop this end and the start that opened its run
        emask_nxt = emask_r & ~at_e;
        smask_nxt = smask_r & ~below_e;
      end else begin
        close_nxt = 1'b0;
      end
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end

    if (load) begin
      smask_nxt      = ld_starts;
      emask_nxt      = ld_ends;
      close_nxt      = hd_map_end && fin_run;
      base_nxt       = hd_base;
      vc_nxt         = hd_count;
      carry_nxt      = open_start_r;
      in_run_nxt     = !hd_map_end && fin_run;
      if (|ld_starts) begin
        open_start_nxt = sat_add(hd_base, OFF_W'(hs_idx));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r     <= 1'b0;
      open_start_r <= '0;
      smask_r      <= '0;
      emask_r      <= '0;
      close_r      <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      in_run_r     <= in_run_nxt;
      open_start_r <= open_start_nxt;
      smask_r      <= smask_nxt;
      emask_r      <= emask_nxt;
      close_r      <= close_nxt;
      ovalid_r     <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    vc_r     <= vc_nxt;
    carry_r  <= carry_nxt;
    ostart_r <= ostart_nxt;
    oend_r   <= oend_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_run_start   = ostart_r;
  assign out_run_end     = oend_r;
  assign out_last_result = olast_r;

endmodule

// ===== rtl/interval_run_extractor.sv =====
// ----------------------------------------------------------------------------
// interval_run_extractor
// Extracts start/end intervals of qualifying loci runs from a stream of
// two-bit-per-locus presence words.
//
//   channel   dir   word contents
//   in_ch     in    locus_pairs, valid_count, map_end
//   out_ch    out   run_start, run_end, last_result
//   cfg_ch    in    set_mode
//
// A word enters whenever the two-entry queue has room.
// The back end emits a word's intervals one after another and loads the next
// word as the last of them is emitted; a word that yields none is still loaded.
// Reset is synchronous and active low; there is no clearing pass.
// An output stall holds the back end; words still enter until the queue is full.
// ----------------------------------------------------------------------------
module interval_run_extractor #(
  parameter int LOCI_PER_WORD = irx_pkg::LOCI_PER_WORD_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  irx_in_if.sink    in_ch,
  irx_out_if.source out_ch,
  irx_cfg_if.sink   cfg_ch
);
  import irx_pkg::*;

  localparam int CNT_W = $clog2(LOCI_PER_WORD + 1);
  localparam int ENT_W = LOCI_PER_WORD + CNT_W + 1 + LOCUS_W;

  logic                     q_wr, q_rd, q_full, q_empty;
  logic [LOCI_PER_WORD-1:0] wr_qual, hd_qual;
  logic [CNT_W-1:0]         wr_count, hd_count;
  logic                     wr_map_end, hd_map_end;
  logic [LOCUS_W-1:0]       wr_base, hd_base;
  logic [ENT_W-1:0]         wr_data, rd_data;

  assign cfg_ch.ready = 1'b1;

  irx_front #(.LOCI(LOCI_PER_WORD)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_locus_pairs (in_ch.locus_pairs),
    .in_valid_count (in_ch.valid_count),
    .in_map_end     (in_ch.map_end),
    .cfg_valid      (cfg_ch.valid),
    .cfg_set_mode   (cfg_ch.set_mode),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .q_qual         (wr_qual),
    .q_count        (wr_count),
    .q_map_end      (wr_map_end),
    .q_base         (wr_base)
  );

  assign wr_data = {wr_qual, wr_count, wr_map_end, wr_base};
  assign {hd_qual, hd_count, hd_map_end, hd_base} = rd_data;

  irx_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (wr_data),
    .rd      (q_rd),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  irx_back #(.LOCI(LOCI_PER_WORD)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hd_empty        (q_empty),
    .hd_rd           (q_rd),
    .hd_qual         (hd_qual),
    .hd_count        (hd_count),
    .hd_map_end      (hd_map_end),
    .hd_base         (hd_base),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_run_start   (out_ch.run_start),
    .out_run_end     (out_ch.run_end),
    .out_last_result (out_ch.last_result)
  );

endmodule

// ===== rtl/irx_chk.sv =====
// ----------------------------------------------------------------------------
// irx_chk
// Port-level checks on the result channel of the interval run extractor,
// bound to the top level.
// ----------------------------------------------------------------------------
module irx_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [irx_pkg::LOCUS_W-1:0]  run_start,
  input logic [irx_pkg::LOCUS_W-1:0]  run_end,
  input logic                         last_result
);
  import irx_pkg::*;

  logic               mid_r, mid_nxt;
  logic [LOCUS_W-1:0] prev_end_r, prev_end_nxt;

  // remember the end of the previous interval of the same input word
  always_comb begin
    mid_nxt      = mid_r;
    prev_end_nxt = prev_end_r;
    if (out_valid && out_ready) begin
      mid_nxt      = !last_result;
      prev_end_nxt = run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r      <= 1'b0;
      prev_end_r <= '0;
    end else begin
      mid_r      <= mid_nxt;
      prev_end_r <= prev_end_nxt;
    end
  end

  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(run_start) && $stable(run_end)
                                && $stable(last_result))
    else $error("result word changed while stalled");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> run_start <= run_end)
    else $error("interval start after its end");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> run_start >= prev_end_r)
    else $error("intervals of one word out of order");

endmodule

bind interval_run_extractor irx_chk u_irx_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .run_start   (out_ch.run_start),
  .run_end     (out_ch.run_end),
  .last_result (out_ch.last_result)
);
